### sv/sliding_window_rate_limiter_macros.svh
`ifndef SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMITER_MACROS_SVH

// same-cycle implication
`define SWRL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/swrl_pkg.sv
`timescale 1ns / 1ps

package swrl_pkg;

  localparam int KEYS       = 256;
  localparam int MAX_EV     = 16;
  localparam int TIME_W     = 32;
  localparam int KEY_BITS   = $clog2(KEYS);
  localparam int SLOT_BITS  = $clog2(MAX_EV);
  localparam int CNT_BITS   = $clog2(MAX_EV + 1);
  localparam int STAMP_ABITS = KEY_BITS + SLOT_BITS;

  localparam int CFG_W      = 5;
  localparam int WIN_W      = 16;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [CFG_W-1:0] MAX_EVENTS_RST = 5'd5;
  localparam logic [WIN_W-1:0] WINDOW_RST     = 16'd60;

  localparam logic REG_MAX_EVENTS = 1'b0;
  localparam logic REG_WINDOW     = 1'b1;

  localparam logic OP_ALLOW = 1'b0;
  localparam logic OP_RESET = 1'b1;

  typedef struct packed {
    logic [SLOT_BITS-1:0] oldest;
    logic [CNT_BITS-1:0]  count;
  } meta_t;

endpackage

### sv/swrl_meta_mem.sv
`timescale 1ns / 1ps

module swrl_meta_mem import swrl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [KEY_BITS-1:0] rd_addr,
  output meta_t               rd_data,
  input  logic                we,
  input  logic [KEY_BITS-1:0] wr_addr,
  input  meta_t               wr_data
);

  meta_t            mem [KEYS];
  logic [KEYS-1:0]  valid;
  meta_t            rd_raw;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // unwritten entries read as the cleared value
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

### sv/swrl_stamp_mem.sv
`timescale 1ns / 1ps

module swrl_stamp_mem import swrl_pkg::*; (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [STAMP_ABITS-1:0] rd_addr,
  output logic [TIME_W-1:0]      rd_data,
  input  logic                   we,
  input  logic [STAMP_ABITS-1:0] wr_addr,
  input  logic [TIME_W-1:0]      wr_data
);

  logic [TIME_W-1:0] mem [KEYS*MAX_EV];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/sliding_window_rate_limiter.sv
// Start to done: a key reset reads the key's metadata and writes it cleared; an allow
// request reads it, expires p stamps (p up to 16) at one stamp memory read per cycle.
// One item at a time: busy is high from acceptance until done; a new item may start
// in the cycle done is high. The receiver cannot stall; done lasts one cycle.
// Reset (rst, synchronous) empties every key at once through per-key valid bits and
// restores an event limit of 5 and a 60 second window; no clearing pass.
`timescale 1ns / 1ps

`include "sliding_window_rate_limiter_macros.svh"

module sliding_window_rate_limiter import swrl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                op,
  input  logic [KEY_BITS-1:0] key_id,
  input  logic [TIME_W-1:0]   now,
  output logic                done,
  output logic                allowed,
  output logic [CNT_BITS-1:0] events_in_window,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  typedef enum logic [1:0] {S_IDLE, S_META, S_CHK, S_DECIDE} state_t;

  state_t               state;
  logic                 op_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [TIME_W-1:0]    now_r;
  logic [TIME_W-1:0]    cutoff;
  logic [SLOT_BITS-1:0] oldest;
  logic [CNT_BITS-1:0]  cnt;
  logic [CFG_W-1:0]     ev_limit;
  logic [WIN_W-1:0]     window_seconds;

  logic                   meta_rd_en;
  meta_t                  meta_rd_data;
  logic                   meta_we;
  meta_t                  meta_wr_data;
  logic                   stamp_rd_en;
  logic [STAMP_ABITS-1:0] stamp_rd_addr;
  logic [TIME_W-1:0]      stamp_rd_data;
  logic                   stamp_we;
  logic [STAMP_ABITS-1:0] stamp_wr_addr;

  logic [TIME_W-1:0]    window_ext;
  logic                 pop_go;
  logic                 expire;
  logic [SLOT_BITS-1:0] oldest_next;
  logic [CNT_BITS-1:0]  cnt_next;
  logic [CNT_BITS-1:0]  limit;
  logic                 admit;
  logic                 cfg_wr;

  assign busy       = (state != S_IDLE);
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign window_ext = TIME_W'(window_seconds);
  assign limit      = (ev_limit > CFG_W'(MAX_EV)) ? CNT_BITS'(MAX_EV)
                                                  : CNT_BITS'(ev_limit);

  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_MAX_EVENTS: prdata = APB_DW'(ev_limit);
      REG_WINDOW:     prdata = APB_DW'(window_seconds);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    meta_rd_en    = (state == S_IDLE) && start;
    meta_we       = 1'b0;
    meta_wr_data  = '0;
    stamp_rd_en   = 1'b0;
    stamp_rd_addr = {key_r, meta_rd_data.oldest};
    stamp_we      = 1'b0;
    stamp_wr_addr = {key_r, oldest + cnt[SLOT_BITS-1:0]};
    pop_go        = (op_r == OP_ALLOW) && (meta_rd_data.count != '0)
                    && (now_r >= window_ext);
    expire        = (stamp_rd_data <= cutoff);
    oldest_next   = oldest + 1'b1;
    cnt_next      = cnt - 1'b1;
    admit         = (cnt < limit);
    case (state)
      S_META: begin
        if (op_r == OP_RESET) begin
          meta_we = 1'b1;
        end else begin
          stamp_rd_en = pop_go;
        end
      end
      S_CHK: begin
        stamp_rd_en   = expire && (cnt_next != '0);
        stamp_rd_addr = {key_r, oldest_next};
      end
      S_DECIDE: begin
        stamp_we            = admit;
        meta_we             = 1'b1;
        meta_wr_data.oldest = oldest;
        meta_wr_data.count  = cnt + CNT_BITS'(admit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      ev_limit       <= MAX_EVENTS_RST;
      window_seconds <= WINDOW_RST;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_MAX_EVENTS: ev_limit       <= pwdata[CFG_W-1:0];
          REG_WINDOW:     window_seconds <= pwdata[WIN_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            op_r  <= op;
            key_r <= key_id;
            now_r <= now;
            state <= S_META;
          end
        end
        S_META: begin
          oldest <= meta_rd_data.oldest;
          cnt    <= meta_rd_data.count;
          cutoff <= now_r - window_ext;
          if (op_r == OP_RESET) begin
            done             <= 1'b1;
            allowed          <= 1'b0;
            events_in_window <= '0;
            state            <= S_IDLE;
          end else if (pop_go) begin
            done  <= 1'b0;
            state <= S_CHK;
          end else begin
            done  <= 1'b0;
            state <= S_DECIDE;
          end
        end
        S_CHK: begin
          done <= 1'b0;
          if (expire) begin
            oldest <= oldest_next;
            cnt    <= cnt_next;
            if (cnt_next == '0) begin
              state <= S_DECIDE;
            end
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          done             <= 1'b1;
          allowed          <= admit;
          events_in_window <= cnt + CNT_BITS'(admit);
          state            <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  swrl_meta_mem u_meta (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (meta_rd_en),
    .rd_addr (key_id),
    .rd_data (meta_rd_data),
    .we      (meta_we),
    .wr_addr (key_r),
    .wr_data (meta_wr_data)
  );

  swrl_stamp_mem u_stamp (
    .clk     (clk),
    .rd_en   (stamp_rd_en),
    .rd_addr (stamp_rd_addr),
    .rd_data (stamp_rd_data),
    .we      (stamp_we),
    .wr_addr (stamp_wr_addr),
    .wr_data (now_r)
  );

  `SWRL_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "done held two cycles")
  `SWRL_ASSERT_NOW(a_end_done, clk, rst, $fell(busy), done, "busy fell without done")
  `SWRL_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not set busy")
  `SWRL_ASSERT_NOW(a_admit_count, clk, rst, done && allowed, events_in_window != '0,
                   "admitted with empty window")
  `SWRL_ASSERT_NOW(a_cnt_range, clk, rst, state == S_DECIDE, cnt <= CNT_BITS'(MAX_EV),
                   "stamp count above capacity")

endmodule

### test/rate_limit_checker.sv
`timescale 1ns / 1ps

module rate_limit_checker import swrl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic                op,
  input  logic [KEY_BITS-1:0] key_id,
  input  logic [TIME_W-1:0]   now,
  input  logic                done,
  input  logic                allowed,
  input  logic [CNT_BITS-1:0] events_in_window,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic [APB_DW-1:0]   prdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  pending
);

  typedef struct packed {
    logic                allowed;
    logic [CNT_BITS-1:0] count;
  } verdict_t;

  logic [TIME_W-1:0]    stamp_log [KEYS][MAX_EV];
  logic [SLOT_BITS-1:0] head_slot [KEYS];
  logic [CNT_BITS-1:0]  fill      [KEYS];
  logic [CFG_W-1:0]     limit_reg;
  logic [WIN_W-1:0]     window_reg;
  verdict_t             verdict_q [$];

  function automatic verdict_t admit_or_deny(input logic op_i, input logic [KEY_BITS-1:0] k,
                                             input logic [TIME_W-1:0] t);
    verdict_t             v;
    logic [TIME_W-1:0]    cutoff;
    logic [CNT_BITS-1:0]  cap;
    logic [SLOT_BITS-1:0] slot;
    v = '0;
    if (op_i == OP_RESET) begin
      fill[k] = '0;
      head_slot[k] = '0;
      return v;
    end
    if (t >= window_reg) begin
      cutoff = t - window_reg;
      while (fill[k] != 0 && stamp_log[k][head_slot[k]] <= cutoff) begin
        head_slot[k] = head_slot[k] + 1'b1;
        fill[k] = fill[k] - 1'b1;
      end
    end
    cap = (limit_reg > MAX_EV) ? CNT_BITS'(MAX_EV) : limit_reg;
    if (fill[k] < cap) begin
      slot = head_slot[k] + fill[k][SLOT_BITS-1:0];
      stamp_log[k][slot] = t;
      fill[k] = fill[k] + 1'b1;
      v.allowed = 1'b1;
    end
    v.count = fill[k];
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst) begin
      foreach (fill[i]) begin
        fill[i] = '0;
        head_slot[i] = '0;
      end
      limit_reg = MAX_EVENTS_RST;
      window_reg = WINDOW_RST;
      verdict_q.delete();
      pending = 0;
      mismatches = 0;
    end else begin
      if (done) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with no item outstanding (allowed %0b count %0d)",
                   $time, allowed, events_in_window);
          mismatches++;
        end else begin
          exp_v = verdict_q[0];
          verdict_q.delete(0);
          if (allowed !== exp_v.allowed) begin
            $display("%0t: allowed expected %0b actual %0b", $time, exp_v.allowed, allowed);
            mismatches++;
          end
          if (events_in_window !== exp_v.count) begin
            $display("%0t: events_in_window expected %0d actual %0d",
                     $time, exp_v.count, events_in_window);
            mismatches++;
          end
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == {REG_MAX_EVENTS, 2'b00}) limit_reg = pwdata[CFG_W-1:0];
          else if (paddr == {REG_WINDOW, 2'b00}) window_reg = pwdata[WIN_W-1:0];
        end else if (paddr == {REG_MAX_EVENTS, 2'b00}) begin
          if (prdata[CFG_W-1:0] !== limit_reg) begin
            $display("%0t: event limit read expected %0d actual %0d",
                     $time, limit_reg, prdata[CFG_W-1:0]);
            mismatches++;
          end
        end else if (paddr == {REG_WINDOW, 2'b00}) begin
          if (prdata[WIN_W-1:0] !== window_reg) begin
            $display("%0t: window_seconds read expected %0d actual %0d",
                     $time, window_reg, prdata[WIN_W-1:0]);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        verdict_q.insert(verdict_q.size(), admit_or_deny(op, key_id, now));
      end
      pending = verdict_q.size();
    end
  end

endmodule

### test/tb_sliding_window_rate_limiter.sv
`timescale 1ns / 1ps

module tb_sliding_window_rate_limiter;
  import swrl_pkg::*;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                op;
  logic [KEY_BITS-1:0] key_id;
  logic [TIME_W-1:0]   now;
  logic                done;
  logic                allowed;
  logic [CNT_BITS-1:0] events_in_window;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  int                  mismatches;
  int                  pending;
  logic                no_gap;

  sliding_window_rate_limiter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .key_id(key_id), .now(now),
    .done(done), .allowed(allowed), .events_in_window(events_in_window),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  rate_limit_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .key_id(key_id), .now(now),
    .done(done), .allowed(allowed), .events_in_window(events_in_window),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready), .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic o, input logic [KEY_BITS-1:0] k,
                           input logic [TIME_W-1:0] t, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    op = o;
    key_id = k;
    now = t;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [APB_DW-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    pwdata = $urandom;
  endtask

  task automatic configure(input logic [CFG_W-1:0] lim, input logic [WIN_W-1:0] win);
    logic [APB_DW-1:0] lim_word;
    logic [APB_DW-1:0] win_word;
    lim_word = ($urandom & ~32'h1F) | APB_DW'(lim);
    win_word = ($urandom & ~32'hFFFF) | APB_DW'(win);
    if ($urandom_range(0, 1)) begin
      apb_access(1'b1, REG_MAX_EVENTS, lim_word);
      apb_access(1'b1, REG_WINDOW, win_word);
    end else begin
      apb_access(1'b1, REG_WINDOW, win_word);
      apb_access(1'b1, REG_MAX_EVENTS, lim_word);
    end
    apb_access(1'b0, REG_MAX_EVENTS, $urandom);
    apb_access(1'b0, REG_WINDOW, $urandom);
  endtask

  initial begin
    logic [TIME_W-1:0]   t_now;
    logic [KEY_BITS-1:0] pool [4];
    logic [KEY_BITS-1:0] k;
    logic [CFG_W-1:0]    lim;
    int                  win;
    int                  r;
    rst = 1'b1;
    start = 1'b0;
    op = OP_ALLOW;
    key_id = '0;
    now = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_gap = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // reset defaults: limit 5, window 60; early times expire nothing
    repeat (6) send_item(OP_ALLOW, 8'd0, 32'd0, pick_gap());
    send_item(OP_ALLOW, 8'd0, 32'd60, pick_gap());
    send_item(OP_ALLOW, 8'd255, 32'hFFFF_FFFF, pick_gap());
    send_item(OP_ALLOW, 8'd255, 32'd5, pick_gap());
    send_item(OP_RESET, 8'd0, $urandom, pick_gap());
    settle();
    // zero limit; old stamp at the head blocks expiry of the rest
    configure(5'd0, 16'd0);
    send_item(OP_ALLOW, 8'd255, 32'd200, pick_gap());
    settle();
    // limit above capacity, then a full ring expires at once
    configure(5'd31, 16'hFFFF);
    repeat (17) send_item(OP_ALLOW, 8'd2, 32'd1000, pick_gap());
    send_item(OP_ALLOW, 8'd2, 32'd1000 + 32'hFFFF, pick_gap());

    for (int p = 0; p < 10; p++) begin
      settle();
      case (p)
        0: begin lim = 5'd16; win = 60;    t_now = 32'd0; end
        1: begin lim = 5'd1;  win = 0;     t_now = $urandom; end
        2: begin lim = 5'd31; win = 65535; t_now = 32'hFFFF_0000 + $urandom_range(0, 65535); end
        3: begin lim = 5'd0;  win = 10;    t_now = $urandom; end
        4: begin lim = 5'd5;  win = 1;     t_now = $urandom; end
        default: begin
          lim = CFG_W'($urandom_range(0, 31));
          win = $urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom_range(0, 65535);
          t_now = $urandom;
        end
      endcase
      configure(lim, win[WIN_W-1:0]);
      foreach (pool[j]) pool[j] = KEY_BITS'($urandom);
      for (int i = 0; i < 175; i++) begin
        if (i % 40 == 0) no_gap = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 5) begin
          send_item(OP_RESET, pool[$urandom_range(0, 3)], $urandom, pick_gap());
        end else begin
          k = (r < 85) ? pool[$urandom_range(0, 3)] : KEY_BITS'($urandom);
          r = $urandom_range(0, 99);
          if (r < 2) t_now = t_now - $urandom_range(1, win + 2);
          else if (r < 80) t_now = t_now + $urandom_range(0, win / 8 + 1);
          else if (r < 95) t_now = t_now + $urandom_range(0, win + 1);
          else t_now = t_now + $urandom_range(win, 3 * win + 10);
          send_item(OP_ALLOW, k, t_now, pick_gap());
        end
      end
    end

    settle();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/swrl_pkg.sv
sv/swrl_meta_mem.sv
sv/swrl_stamp_mem.sv
sv/sliding_window_rate_limiter.sv
test/rate_limit_checker.sv
test/tb_sliding_window_rate_limiter.sv
